>>> rtl/core/mrbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbt_pkg
// Types, state codes and Manchester coding functions for the radio byte
// transceiver.
// ----------------------------------------------------------------------------
package mrbt_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [2:0] OP_SEND   = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_SAMPLE = 3'd2;
    localparam logic [2:0] OP_POWER  = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;

    // Mode state codes.
    localparam logic [2:0] ST_SEARCH    = 3'd0;
    localparam logic [2:0] ST_TX_IDLE   = 3'd2;
    localparam logic [2:0] ST_TX_QUEUED = 3'd4;
    localparam logic [2:0] ST_RX_START  = 3'd5;
    localparam logic [2:0] ST_RX_DATA   = 3'd6;
    localparam logic [2:0] ST_OFF       = 3'd7;

    // Held-sample marker meaning no sample is pending.
    localparam logic [1:0] NO_SAMPLE = 2'd2;

    // Start frame bytes.
    localparam logic [7:0] SYNC_HIGH = 8'h99;
    localparam logic [7:0] SYNC_LOW  = 8'h9a;

    // Bit rate codes.
    localparam logic [1:0] RATE_SEARCH = 2'd0;
    localparam logic [1:0] RATE_ALIGN  = 2'd1;
    localparam logic [1:0] RATE_DATA   = 2'd2;

    // Radio mode codes.
    localparam logic [1:0] RADIO_OFF = 2'd0;
    localparam logic [1:0] RADIO_RX  = 2'd1;
    localparam logic [1:0] RADIO_TX  = 2'd2;

    localparam int unsigned OUT_TDATA_W = 24;

    typedef struct packed {
        logic       accepted;
        logic       tx_bit_valid;
        logic       tx_bit;
        logic       tx_byte_ready;
        logic       tx_done;
        logic       rx_byte_valid;
        logic [7:0] rx_byte;
        logic [1:0] bit_rate;
        logic [1:0] radio_mode;
    } t_result;

    // Each data bit i goes to code bit 2i+1, its complement to code bit 2i.
    function automatic logic [7:0] man_encode(input logic [3:0] nib);
        logic [7:0] c;
        for (int i = 0; i < 4; i++) begin
            c[2*i+1] = nib[i];
            c[2*i]   = ~nib[i];
        end
        return c;
    endfunction

    function automatic logic [7:0] man_decode(input logic [7:0] hi, input logic [7:0] lo);
        return {hi[7], hi[5], hi[3], hi[1], lo[7], lo[5], lo[3], lo[1]};
    endfunction

endpackage

>>> rtl/core/mrbt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbt_step
// Transceiver state registers and the per-item update logic. The result of
// an item is formed combinationally from the current state and the item.
// ----------------------------------------------------------------------------
module mrbt_step
    import mrbt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_data_in,
    input  logic       i_power_on,
    output t_result    o_result
);

    logic [2:0] r_mode,       n_mode;
    logic [7:0] r_shift_high, n_shift_high;
    logic [7:0] r_shift_low,  n_shift_low;
    logic [7:0] r_code_high,  n_code_high;
    logic [7:0] r_code_low,   n_code_low;
    logic [4:0] r_bit_count,  n_bit_count;
    logic [1:0] r_prev,       n_prev;
    logic [1:0] r_rate,       n_rate;

    logic       cur_tx;
    logic       sample;
    logic [4:0] count_inc;
    logic [7:0] srch_high;
    logic [7:0] srch_low;
    logic [7:0] rx_high;

    assign cur_tx    = (r_mode >= 3'd1) && (r_mode <= 3'd4);
    assign sample    = i_data_in[0];
    assign count_inc = r_bit_count + 5'd1;
    assign srch_high = {sample, r_shift_high[7:1]};
    assign srch_low  = {r_shift_high[0], r_shift_low[7:1]};
    assign rx_high   = {sample, r_shift_high[7:1]};

    always_comb begin
        n_mode       = r_mode;
        n_shift_high = r_shift_high;
        n_shift_low  = r_shift_low;
        n_code_high  = r_code_high;
        n_code_low   = r_code_low;
        n_bit_count  = r_bit_count;
        n_prev       = r_prev;
        n_rate       = r_rate;

        o_result               = '0;

        unique case (i_operation)
            OP_SEND: begin
                if (r_mode == ST_SEARCH) begin
                    n_code_low        = man_encode(i_data_in[3:0]);
                    n_code_high       = man_encode(i_data_in[7:4]);
                    n_shift_high      = SYNC_HIGH;
                    n_shift_low       = SYNC_LOW;
                    n_bit_count       = '0;
                    n_mode            = ST_TX_QUEUED;
                    n_rate            = RATE_DATA;
                    o_result.accepted = 1'b1;
                end else if (r_mode == ST_TX_IDLE) begin
                    n_code_low        = man_encode(i_data_in[3:0]);
                    n_code_high       = man_encode(i_data_in[7:4]);
                    n_mode            = ST_TX_QUEUED;
                    o_result.accepted = 1'b1;
                end
            end
            OP_TICK: begin
                if (cur_tx) begin
                    o_result.accepted     = 1'b1;
                    o_result.tx_bit_valid = 1'b1;
                    o_result.tx_bit       = r_shift_low[0];
                    n_shift_low           = {1'b0, r_shift_low[7:1]};
                    n_bit_count           = count_inc;
                    if (count_inc == 5'd8) begin
                        n_shift_low = r_shift_high;
                    end else if (count_inc == 5'd16) begin
                        o_result.tx_byte_ready = 1'b1;
                        // A queued byte starts its word; otherwise the frame ends.
                        if (r_mode == ST_TX_QUEUED) begin
                            n_shift_high = r_code_high;
                            n_shift_low  = r_code_low;
                            n_bit_count  = '0;
                            n_mode       = ST_TX_IDLE;
                        end else begin
                            n_mode           = ST_SEARCH;
                            n_rate           = RATE_SEARCH;
                            o_result.tx_done = 1'b1;
                        end
                    end
                end
            end
            OP_SAMPLE: begin
                if (r_mode == ST_SEARCH) begin
                    // Samples arrive doubled: only a repeated value is shifted in.
                    if (r_prev != {1'b0, sample}) begin
                        n_prev = {1'b0, sample};
                    end else begin
                        n_prev       = NO_SAMPLE;
                        n_shift_high = srch_high;
                        n_shift_low  = srch_low;
                        if ((srch_high == SYNC_HIGH) && (srch_low == SYNC_LOW)) begin
                            n_mode      = ST_RX_START;
                            n_bit_count = '0;
                            n_rate      = RATE_ALIGN;
                        end
                    end
                end else if (r_mode == ST_RX_START) begin
                    n_rate       = RATE_DATA;
                    n_mode       = ST_RX_DATA;
                    n_bit_count  = 5'd1;
                    n_shift_high = {sample, 7'd0};
                end else if (r_mode == ST_RX_DATA) begin
                    n_bit_count  = count_inc;
                    n_shift_high = rx_high;
                    if (count_inc == 5'd8) begin
                        n_code_low = rx_high;
                    end else if (count_inc == 5'd16) begin
                        n_bit_count            = '0;
                        n_code_high            = rx_high;
                        n_mode                 = ST_RX_START;
                        o_result.rx_byte_valid = 1'b1;
                        o_result.rx_byte       = man_decode(rx_high, r_code_low);
                    end
                end
            end
            OP_POWER: begin
                if (i_power_on) begin
                    n_mode = ST_SEARCH;
                    n_rate = RATE_SEARCH;
                end else begin
                    n_mode = ST_OFF;
                end
            end
            OP_STOP: begin
                if ((r_mode == ST_RX_START) || (r_mode == ST_RX_DATA)) begin
                    n_mode = ST_SEARCH;
                    n_rate = RATE_SEARCH;
                end
            end
            default: begin
            end
        endcase

        o_result.bit_rate = n_rate;
        if (n_mode == ST_OFF) begin
            o_result.radio_mode = RADIO_OFF;
        end else if ((n_mode >= 3'd1) && (n_mode <= 3'd4)) begin
            o_result.radio_mode = RADIO_TX;
        end else begin
            o_result.radio_mode = RADIO_RX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= ST_SEARCH;
            r_shift_high <= '0;
            r_shift_low  <= '0;
            r_code_high  <= '0;
            r_code_low   <= '0;
            r_bit_count  <= '0;
            r_prev       <= '0;
            r_rate       <= RATE_SEARCH;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_shift_high <= n_shift_high;
            r_shift_low  <= n_shift_low;
            r_code_high  <= n_code_high;
            r_code_low   <= n_code_low;
            r_bit_count  <= n_bit_count;
            r_prev       <= n_prev;
            r_rate       <= n_rate;
        end
    end

endmodule

>>> rtl/core/mrbt_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbt_out_reg
// Result register on the output stream. It takes a new item whenever it is
// empty or its current item is leaving in the same cycle.
// ----------------------------------------------------------------------------
module mrbt_out_reg
    import mrbt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_result                i_result,
    output logic                   o_ready,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_data;
    logic [OUT_TDATA_W-1:0] n_data;

    assign o_ready = !r_valid || m_axis_tready;

    assign n_data = {6'd0,
                     i_result.radio_mode,
                     i_result.bit_rate,
                     i_result.rx_byte,
                     i_result.rx_byte_valid,
                     i_result.tx_done,
                     i_result.tx_byte_ready,
                     i_result.tx_bit,
                     i_result.tx_bit_valid,
                     i_result.accepted};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

endmodule

>>> rtl/core/manchester_radio_byte_transceiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manchester_radio_byte_transceiver_unit
// The result of an item is on the output in the cycle after it is taken.
// Throughput: one item per cycle while m_axis_tready does not stall; the state
// update is a single shift/compare step between state and output registers.
// Reset (synchronous, active low) returns the radio to receive search with all
// shift, code and count registers cleared and the output register empty.
// ----------------------------------------------------------------------------
module manchester_radio_byte_transceiver_unit
    import mrbt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [7:0] data_in, [8] power_on, [15:9] zero
    input  logic [15:0]            s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] accepted, [1] tx_bit_valid, [2] tx_bit, [3] tx_byte_ready, [4] tx_done,
    // [5] rx_byte_valid, [13:6] rx_byte, [15:14] bit_rate, [17:16] radio_mode,
    // [23:18] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic    accept;
    logic    out_ready;
    t_result result;

    assign s_axis_tready = out_ready;
    assign accept        = s_axis_tvalid && out_ready;

    mrbt_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (s_axis_tuser),
        .i_data_in   (s_axis_tdata[7:0]),
        .i_power_on  (s_axis_tdata[8]),
        .o_result    (result)
    );

    mrbt_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept),
        .i_result      (result),
        .o_ready       (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
